// ===== rtl/sortable_event_table_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Sortable event table assertion macros
// Immediate and next-cycle implication checks on the rising clock edge.
// Each macro uses clk and rst_n from the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef SORTABLE_EVENT_TABLE_UNIT_MACROS_SVH
`define SORTABLE_EVENT_TABLE_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define SETBL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SETBL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/setbl_pkg.sv =====
// ---------------------------------------------------------------------------
// Sortable event table package
// Field widths, operation codes, fixed-point constants and shared types.
// ---------------------------------------------------------------------------
package setbl_pkg;

  localparam int MAX_EVENTS_DEF = 256;
  localparam int SLOT_W         = 16;
  localparam int IN_W           = 18;
  localparam int FX_W           = 17;
  localparam int OP_W           = 3;

  localparam logic [FX_W-1:0] ONE_FX  = 17'h10000;
  localparam logic [FX_W-1:0] ZERO_FX = 17'h00000;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 3'd0,
    OP_SET_POS = 3'd1,
    OP_SET_VEL = 3'd2,
    OP_APPEND  = 3'd3,
    OP_RESIZE  = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_SORT    = 3'd6
  } op_t;

  typedef struct packed {
    logic            pos_en;
    logic            vel_en;
    logic [FX_W-1:0] pos;
    logic [FX_W-1:0] vel;
  } wr_t;

  typedef struct packed {
    logic [FX_W-1:0] pos;
    logic [FX_W-1:0] vel;
    logic            ign;
  } res_t;

  function automatic logic [FX_W-1:0] clamp_unit(input logic signed [IN_W-1:0] raw);
    logic [FX_W-1:0] val;
    val = ZERO_FX;
    if (raw[IN_W-1]) begin
      val = ZERO_FX;
    end else if (raw[IN_W-2:0] > ONE_FX) begin
      val = ONE_FX;
    end else begin
      val = raw[FX_W-1:0];
    end
    return val;
  endfunction

endpackage

// ===== rtl/setbl_store.sv =====
// ---------------------------------------------------------------------------
// Sortable event table storage
// Position and velocity memories: one write address, one read address,
// registered read data.
// ---------------------------------------------------------------------------
module setbl_store #(
  parameter int DEPTH = setbl_pkg::MAX_EVENTS_DEF
) (
  input  logic                          clk,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  setbl_pkg::wr_t                wr,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [setbl_pkg::FX_W-1:0]    rd_pos,
  output logic [setbl_pkg::FX_W-1:0]    rd_vel
);

  logic [setbl_pkg::FX_W-1:0] pos_mem [DEPTH];
  logic [setbl_pkg::FX_W-1:0] vel_mem [DEPTH];
  logic [setbl_pkg::FX_W-1:0] rd_pos_r;
  logic [setbl_pkg::FX_W-1:0] rd_vel_r;

  always_ff @(posedge clk) begin
    if (wr.pos_en) begin
      pos_mem[wr_addr] <= wr.pos;
    end
    if (wr.vel_en) begin
      vel_mem[wr_addr] <= wr.vel;
    end
    rd_pos_r <= pos_mem[rd_addr];
    rd_vel_r <= vel_mem[rd_addr];
  end

  assign rd_pos = rd_pos_r;
  assign rd_vel = rd_vel_r;

endmodule

// ===== rtl/setbl_seq.sv =====
// ---------------------------------------------------------------------------
// Sortable event table sequencer
// Decodes one operation, walks the memory for resize fill and insertion
// sort through a single read and write port, and hands back one result.
// ---------------------------------------------------------------------------
module setbl_seq #(
  parameter int MAX_EVENTS = setbl_pkg::MAX_EVENTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic [setbl_pkg::OP_W-1:0]              in_op,
  input  logic [setbl_pkg::SLOT_W-1:0]            in_slot,
  input  logic signed [setbl_pkg::IN_W-1:0]       in_pos,
  input  logic signed [setbl_pkg::IN_W-1:0]       in_vel,
  input  logic [setbl_pkg::SLOT_W-1:0]            in_new_count,
  output logic                                    idle,
  input  logic                                    can_load,
  output logic                                    emit,
  output setbl_pkg::res_t                         res,
  output logic [$clog2(MAX_EVENTS+1)-1:0]         res_count,
  output logic [$clog2(MAX_EVENTS)-1:0]           wr_addr,
  output setbl_pkg::wr_t                          wr,
  output logic [$clog2(MAX_EVENTS)-1:0]           rd_addr,
  input  logic [setbl_pkg::FX_W-1:0]              rd_pos,
  input  logic [setbl_pkg::FX_W-1:0]              rd_vel
);

  localparam int IDX_W = $clog2(MAX_EVENTS);
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int FX_W  = setbl_pkg::FX_W;
  localparam int SLOT_W = setbl_pkg::SLOT_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_FILL   = 8'b0000_1000,
    S_KEY    = 8'b0001_0000,
    S_CMP    = 8'b0010_0000,
    S_PLACE  = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  setbl_pkg::op_t        op_r, op_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [FX_W-1:0]       pos_r, pos_nxt;
  logic [FX_W-1:0]       vel_r, vel_nxt;
  logic [CNT_W-1:0]      req_r, req_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [IDX_W-1:0]      i_r, i_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [FX_W-1:0]       key_pos_r, key_pos_nxt;
  logic [FX_W-1:0]       key_vel_r, key_vel_nxt;

  logic                  in_range;
  logic                  full;
  logic [CNT_W-1:0]      ip1;
  logic [CNT_W-1:0]      fill_p1;

  assign in_range = slot_r < SLOT_W'(count_r);
  assign full     = count_r == CNT_W'(MAX_EVENTS);
  assign ip1      = CNT_W'(i_r) + CNT_W'(1);
  assign fill_p1  = fill_r + CNT_W'(1);
  assign idle     = state_r == S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    slot_nxt    = slot_r;
    pos_nxt     = pos_r;
    vel_nxt     = vel_r;
    req_nxt     = req_r;
    fill_nxt    = fill_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    key_pos_nxt = key_pos_r;
    key_vel_nxt = key_vel_r;
    emit        = 1'b0;
    res         = '{pos: setbl_pkg::ZERO_FX, vel: setbl_pkg::ZERO_FX, ign: 1'b0};
    wr          = '{pos_en: 1'b0, vel_en: 1'b0, pos: pos_r, vel: vel_r};
    wr_addr     = slot_r[IDX_W-1:0];
    rd_addr     = slot_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = setbl_pkg::op_t'(in_op);
          slot_nxt = in_slot;
          pos_nxt  = setbl_pkg::clamp_unit(in_pos);
          vel_nxt  = setbl_pkg::clamp_unit(in_vel);
          if (in_new_count > SLOT_W'(MAX_EVENTS)) begin
            req_nxt = CNT_W'(MAX_EVENTS);
          end else begin
            req_nxt = in_new_count[CNT_W-1:0];
          end
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (op_r)
          setbl_pkg::OP_READ: begin
            if (in_range) begin
              state_nxt = S_READ;
            end else begin
              res.vel = setbl_pkg::ONE_FX;
              res.ign = 1'b1;
              emit    = can_load;
              if (can_load) begin
                state_nxt = S_IDLE;
              end
            end
          end
          setbl_pkg::OP_SET_POS, setbl_pkg::OP_SET_VEL: begin
            res.ign = !in_range;
            if (can_load) begin
              emit      = 1'b1;
              wr.pos_en = in_range && (op_r == setbl_pkg::OP_SET_POS);
              wr.vel_en = in_range && (op_r == setbl_pkg::OP_SET_VEL);
              state_nxt = S_IDLE;
            end
          end
          setbl_pkg::OP_APPEND: begin
            res.ign = full;
            wr_addr = count_r[IDX_W-1:0];
            if (can_load) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (!full) begin
                wr.pos_en = 1'b1;
                wr.vel_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end
          setbl_pkg::OP_RESIZE: begin
            if (req_r > count_r) begin
              fill_nxt  = count_r;
              state_nxt = S_FILL;
            end else if (can_load) begin
              count_nxt = req_r;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          setbl_pkg::OP_CLEAR: begin
            if (can_load) begin
              count_nxt = '0;
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          setbl_pkg::OP_SORT: begin
            if (count_r < CNT_W'(2)) begin
              emit = can_load;
              if (can_load) begin
                state_nxt = S_IDLE;
              end
            end else begin
              i_nxt     = IDX_W'(1);
              rd_addr   = IDX_W'(1);
              state_nxt = S_KEY;
            end
          end
          default: begin
            emit = can_load;
            if (can_load) begin
              state_nxt = S_IDLE;
            end
          end
        endcase
      end

      S_READ: begin
        res.pos = rd_pos;
        res.vel = rd_vel;
        emit    = can_load;
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end

      S_FILL: begin
        wr_addr   = fill_r[IDX_W-1:0];
        wr.pos_en = 1'b1;
        wr.vel_en = 1'b1;
        wr.pos    = setbl_pkg::ZERO_FX;
        wr.vel    = setbl_pkg::ONE_FX;
        fill_nxt  = fill_p1;
        if (fill_p1 == req_r) begin
          count_nxt = req_r;
          state_nxt = S_FIN;
        end
      end

      S_KEY: begin
        key_pos_nxt = rd_pos;
        key_vel_nxt = rd_vel;
        j_nxt       = i_r;
        rd_addr     = i_r - IDX_W'(1);
        state_nxt   = S_CMP;
      end

      S_CMP: begin
        rd_addr = j_r - IDX_W'(2);
        wr_addr = j_r;
        wr.pos  = rd_pos;
        wr.vel  = rd_vel;
        if (rd_pos > key_pos_r) begin
          wr.pos_en = 1'b1;
          wr.vel_en = 1'b1;
          j_nxt     = j_r - IDX_W'(1);
          if (j_r == IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        wr_addr   = j_r;
        wr.pos_en = 1'b1;
        wr.vel_en = 1'b1;
        wr.pos    = key_pos_r;
        wr.vel    = key_vel_r;
        rd_addr   = i_r + IDX_W'(1);
        if (ip1 < count_r) begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_KEY;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        emit = can_load;
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    slot_r    <= slot_nxt;
    pos_r     <= pos_nxt;
    vel_r     <= vel_nxt;
    req_r     <= req_nxt;
    fill_r    <= fill_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    key_pos_r <= key_pos_nxt;
    key_vel_r <= key_vel_nxt;
  end

endmodule

// ===== rtl/sortable_event_table_unit.sv =====
// ---------------------------------------------------------------------------
// Sortable event table
// Table of position/velocity events with read, set, append, resize, clear
// and stable insertion sort by position.
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_stall | operation, slot, position_in, velocity_in,
//           |                     | new_count
//  out      | out_valid/out_stall | position_out, velocity_out, count_out, ignored
//
//  Set, append, clear and an out-of-range read answer from the decode state;
//  an in-range read adds a memory read. Resize answers from decode to shrink;
//  to grow it fills each new slot in turn, then answers. Sort over N events
//  walks one key at a time, shifting entries through the single read port.
//  Reset clears the event count and output valid; memory contents are not cleared.
//  A stalled result holds in the output register; the next beat is taken
//  meanwhile and its result waits until the register frees up.
// ---------------------------------------------------------------------------
module sortable_event_table_unit #(
  parameter int MAX_EVENTS = setbl_pkg::MAX_EVENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [setbl_pkg::OP_W-1:0]           in_operation,
  input  logic [setbl_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [setbl_pkg::IN_W-1:0]    in_position_in,
  input  logic signed [setbl_pkg::IN_W-1:0]    in_velocity_in,
  input  logic [setbl_pkg::SLOT_W-1:0]         in_new_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [setbl_pkg::FX_W-1:0]           out_position_out,
  output logic [setbl_pkg::FX_W-1:0]           out_velocity_out,
  output logic [$clog2(MAX_EVENTS+1)-1:0]      out_count_out,
  output logic                                 out_ignored
);

  localparam int IDX_W = $clog2(MAX_EVENTS);
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);

  logic                         seq_idle;
  logic                         can_load;
  logic                         emit;
  setbl_pkg::res_t              res;
  logic [CNT_W-1:0]             res_count;
  logic [IDX_W-1:0]             wr_addr;
  setbl_pkg::wr_t               wr;
  logic [IDX_W-1:0]             rd_addr;
  logic [setbl_pkg::FX_W-1:0]   rd_pos;
  logic [setbl_pkg::FX_W-1:0]   rd_vel;

  logic                         out_valid_r, out_valid_nxt;
  logic [setbl_pkg::FX_W-1:0]   out_pos_r;
  logic [setbl_pkg::FX_W-1:0]   out_vel_r;
  logic [CNT_W-1:0]             out_count_r;
  logic                         out_ign_r;

  assign can_load = !out_valid_r || !out_stall;
  assign in_stall = !seq_idle;

  setbl_seq #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_op        (in_operation),
    .in_slot      (in_slot),
    .in_pos       (in_position_in),
    .in_vel       (in_velocity_in),
    .in_new_count (in_new_count),
    .idle         (seq_idle),
    .can_load     (can_load),
    .emit         (emit),
    .res          (res),
    .res_count    (res_count),
    .wr_addr      (wr_addr),
    .wr           (wr),
    .rd_addr      (rd_addr),
    .rd_pos       (rd_pos),
    .rd_vel       (rd_vel)
  );

  setbl_store #(
    .DEPTH (MAX_EVENTS)
  ) u_store (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_pos  (rd_pos),
    .rd_vel  (rd_vel)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pos_r   <= res.pos;
      out_vel_r   <= res.vel;
      out_count_r <= res_count;
      out_ign_r   <= res.ign;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position_out = out_pos_r;
  assign out_velocity_out = out_vel_r;
  assign out_count_out    = out_count_r;
  assign out_ignored      = out_ign_r;

endmodule

// ===== rtl/setbl_checker.sv =====
// ---------------------------------------------------------------------------
// Sortable event table checker
// Port-level checks on result beats, bound to the top level.
// ---------------------------------------------------------------------------
`include "sortable_event_table_unit_macros.svh"

module setbl_checker #(
  parameter int MAX_EVENTS = setbl_pkg::MAX_EVENTS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [setbl_pkg::FX_W-1:0]        out_position_out,
  input logic [setbl_pkg::FX_W-1:0]        out_velocity_out,
  input logic [$clog2(MAX_EVENTS+1)-1:0]   out_count_out,
  input logic                              out_ignored
);

  localparam int CNT_W = $clog2(MAX_EVENTS + 1);

  `SETBL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_position_out) && $stable(out_velocity_out) && $stable(out_count_out) && $stable(out_ignored), "stalled result beat changed")
  `SETBL_ASSERT_IMP(a_ign_pos, out_valid && out_ignored, out_position_out == setbl_pkg::ZERO_FX, "refused beat carries a position")
  `SETBL_ASSERT_IMP(a_fx_range, out_valid, (out_position_out <= setbl_pkg::ONE_FX) && (out_velocity_out <= setbl_pkg::ONE_FX), "result value above 1.0")
  `SETBL_ASSERT_IMP(a_count_max, out_valid, out_count_out <= CNT_W'(MAX_EVENTS), "event count above capacity")

endmodule

bind sortable_event_table_unit setbl_checker #(
  .MAX_EVENTS (MAX_EVENTS)
) u_setbl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_position_out (out_position_out),
  .out_velocity_out (out_velocity_out),
  .out_count_out    (out_count_out),
  .out_ignored      (out_ignored)
);

// ===== tb/tb_sortable_event_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sortable event table testbench
// Drives read, set, append, resize, clear and sort beats through the
// valid/stall input channel, predicts every reply with a private copy of the
// event table, and compares each reply beat field by field in order. Both
// channels idle in random bursts; one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_sortable_event_table_unit;

  localparam int TABLE_DEPTH = setbl_pkg::MAX_EVENTS_DEF;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int FX_W = setbl_pkg::FX_W;
  localparam int IN_W = setbl_pkg::IN_W;
  localparam int OP_W = setbl_pkg::OP_W;
  localparam int SLOT_W = setbl_pkg::SLOT_W;
  localparam logic [FX_W-1:0] ONE_FX = setbl_pkg::ONE_FX;
  localparam logic [FX_W-1:0] ZERO_FX = setbl_pkg::ZERO_FX;
  localparam int CLK_HALF = 6;
  localparam int BIG_TABLE = 48;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam logic signed [IN_W-1:0] NEG_MIN = 18'sh20000;
  localparam logic signed [IN_W-1:0] POS_MAX = 18'sh1FFFF;

  typedef struct {
    logic [FX_W-1:0]  pos;
    logic [FX_W-1:0]  vel;
    logic [CNT_W-1:0] cnt;
    logic             ign;
  } table_reply_t;

  class event_table_scoreboard;
    logic [FX_W-1:0] pos_mem [TABLE_DEPTH];
    logic [FX_W-1:0] vel_mem [TABLE_DEPTH];
    int              n_events;
    table_reply_t    replies [$];
    int              errors;

    function new();
      n_events = 0;
      errors = 0;
      foreach (pos_mem[i]) begin
        pos_mem[i] = ZERO_FX;
        vel_mem[i] = ZERO_FX;
      end
    endfunction

    function logic [FX_W-1:0] saturate_unit(logic signed [IN_W-1:0] raw);
      int v;
      v = int'(raw);
      if (v < 0) return ZERO_FX;
      if (v > 65536) return ONE_FX;
      return v[FX_W-1:0];
    endfunction

    function void sort_by_position();
      logic [FX_W-1:0] kp;
      logic [FX_W-1:0] kv;
      int j;
      for (int i = 1; i < n_events; i++) begin
        kp = pos_mem[i];
        kv = vel_mem[i];
        j = i;
        while (j > 0 && pos_mem[j-1] > kp) begin
          pos_mem[j] = pos_mem[j-1];
          vel_mem[j] = vel_mem[j-1];
          j--;
        end
        pos_mem[j] = kp;
        vel_mem[j] = kv;
      end
    endfunction

    function void note_beat(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                            logic signed [IN_W-1:0] p, logic signed [IN_W-1:0] v,
                            logic [SLOT_W-1:0] req);
      table_reply_t r;
      logic [FX_W-1:0] pc;
      logic [FX_W-1:0] vc;
      int target;
      pc = saturate_unit(p);
      vc = saturate_unit(v);
      r.pos = ZERO_FX;
      r.vel = ZERO_FX;
      r.ign = 1'b0;
      case (op)
        setbl_pkg::OP_READ: begin
          if (slot < n_events) begin
            r.pos = pos_mem[slot];
            r.vel = vel_mem[slot];
          end else begin
            r.vel = ONE_FX;
            r.ign = 1'b1;
          end
        end
        setbl_pkg::OP_SET_POS: begin
          if (slot < n_events) pos_mem[slot] = pc;
          else r.ign = 1'b1;
        end
        setbl_pkg::OP_SET_VEL: begin
          if (slot < n_events) vel_mem[slot] = vc;
          else r.ign = 1'b1;
        end
        setbl_pkg::OP_APPEND: begin
          if (n_events < TABLE_DEPTH) begin
            pos_mem[n_events] = pc;
            vel_mem[n_events] = vc;
            n_events++;
          end else begin
            r.ign = 1'b1;
          end
        end
        setbl_pkg::OP_RESIZE: begin
          target = (req > TABLE_DEPTH) ? TABLE_DEPTH : int'(req);
          for (int i = n_events; i < target; i++) begin
            pos_mem[i] = ZERO_FX;
            vel_mem[i] = ONE_FX;
          end
          n_events = target;
        end
        setbl_pkg::OP_CLEAR: n_events = 0;
        setbl_pkg::OP_SORT:  sort_by_position();
        default: ;
      endcase
      r.cnt = n_events[CNT_W-1:0];
      replies.push_back(r);
    endfunction

    task report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch %s: expected %0d, got %0d", $time, field, want, got);
      errors++;
    endtask

    task check_beat(logic [FX_W-1:0] pos, logic [FX_W-1:0] vel,
                    logic [CNT_W-1:0] cnt, logic ign);
      table_reply_t e;
      if (replies.size() == 0) begin
        report_mismatch("unexpected reply, count_out", 32'd0, 32'(cnt));
        return;
      end
      e = replies.pop_front();
      if (pos !== e.pos) report_mismatch("position_out", 32'(e.pos), 32'(pos));
      if (vel !== e.vel) report_mismatch("velocity_out", 32'(e.vel), 32'(vel));
      if (cnt !== e.cnt) report_mismatch("count_out", 32'(e.cnt), 32'(cnt));
      if (ign !== e.ign) report_mismatch("ignored", 32'(e.ign), 32'(ign));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OP_W-1:0]        in_operation = setbl_pkg::OP_READ;
  logic [SLOT_W-1:0]      in_slot = '0;
  logic signed [IN_W-1:0] in_position_in = '0;
  logic signed [IN_W-1:0] in_velocity_in = '0;
  logic [SLOT_W-1:0]      in_new_count = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FX_W-1:0]        out_position_out;
  logic [FX_W-1:0]        out_velocity_out;
  logic [CNT_W-1:0]       out_count_out;
  logic                   out_ignored;

  event_table_scoreboard table_sb = new();
  bit idle_on = 1'b1;
  int hold_cycles = 0;
  int beats_sent = 0;
  int big_sorts_left = 2;

  sortable_event_table_unit #(
    .MAX_EVENTS(TABLE_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_slot          (in_slot),
    .in_position_in   (in_position_in),
    .in_velocity_in   (in_velocity_in),
    .in_new_count     (in_new_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position_out (out_position_out),
    .out_velocity_out (out_velocity_out),
    .out_count_out    (out_count_out),
    .out_ignored      (out_ignored)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    #36000000;
    $display("tb_sortable_event_table_unit: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      table_sb.check_beat(out_position_out, out_velocity_out, out_count_out, out_ignored);
  end

  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic signed [IN_W-1:0] p,
                           input logic signed [IN_W-1:0] v,
                           input logic [SLOT_W-1:0] req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_slot        <= slot;
    in_position_in <= p;
    in_velocity_in <= v;
    in_new_count   <= req;
    do @(posedge clk); while (in_stall);
    table_sb.note_beat(op, slot, p, v, req);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (table_sb.replies.size() != 0);
  endtask

  function automatic logic signed [IN_W-1:0] pick_level();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return NEG_MIN;
    if (kind == 1) return POS_MAX;
    if (kind == 2) return IN_W'($urandom_range(65535, 65537));
    if (kind == 3) return IN_W'(-int'($urandom_range(1, 3)));
    if (kind <= 5) return IN_W'($urandom_range(0, 4) * 16384);
    return IN_W'($urandom_range(0, 262143));
  endfunction

  function automatic logic [SLOT_W-1:0] pick_any();
    return SLOT_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7 && table_sb.n_events > 0)
      return SLOT_W'($urandom_range(0, table_sb.n_events - 1));
    if (kind < 8) return SLOT_W'(table_sb.n_events);
    return pick_any();
  endfunction

  function automatic logic [SLOT_W-1:0] pick_count();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 8) return SLOT_W'($urandom_range(0, 40));
    if (kind < 9) return SLOT_W'($urandom_range(0, 300));
    return pick_any();
  endfunction

  task automatic random_beat();
    int pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 28) op = setbl_pkg::OP_READ;
    else if (pick < 40) op = setbl_pkg::OP_SET_POS;
    else if (pick < 52) op = setbl_pkg::OP_SET_VEL;
    else if (pick < 72) op = setbl_pkg::OP_APPEND;
    else if (pick < 80) op = setbl_pkg::OP_RESIZE;
    else if (pick < 84) op = setbl_pkg::OP_CLEAR;
    else if (pick < 96) op = setbl_pkg::OP_SORT;
    else op = OP_UNUSED;
    if (op == setbl_pkg::OP_SORT && table_sb.n_events > BIG_TABLE) begin
      if (big_sorts_left > 0) big_sorts_left--;
      else op = setbl_pkg::OP_CLEAR;
    end
    send_beat(op, pick_slot(), pick_level(), pick_level(), pick_count());
  endtask

  task automatic fill_sort_readback();
    int k;
    k = $urandom_range(1, 24);
    send_beat(setbl_pkg::OP_CLEAR, pick_any(), pick_level(), pick_level(), pick_any());
    repeat (k)
      send_beat(setbl_pkg::OP_APPEND, pick_any(), pick_level(), pick_level(), pick_any());
    repeat ($urandom_range(0, 3))
      send_beat($urandom_range(0, 1) ? setbl_pkg::OP_SET_POS : setbl_pkg::OP_SET_VEL,
                pick_slot(), pick_level(), pick_level(), pick_any());
    send_beat(setbl_pkg::OP_SORT, pick_any(), pick_level(), pick_level(), pick_any());
    for (int i = 0; i <= k; i++)
      send_beat(setbl_pkg::OP_READ, SLOT_W'(i), pick_level(), pick_level(), pick_any());
  endtask

  task automatic run_mix(int target);
    while (beats_sent < target) begin
      if ($urandom_range(0, 9) < 4) fill_sort_readback();
      else random_beat();
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(setbl_pkg::OP_READ, 0, 0, 0, 0);
    send_beat(setbl_pkg::OP_SET_POS, 0, IN_W'(ONE_FX), IN_W'(ONE_FX), 0);
    send_beat(setbl_pkg::OP_APPEND, 0, NEG_MIN, POS_MAX, 0);
    send_beat(setbl_pkg::OP_APPEND, 0, 18'sd65537, -18'sd1, 0);
    send_beat(setbl_pkg::OP_APPEND, 0, 18'sd65535, 18'sd65535, 0);
    send_beat(setbl_pkg::OP_APPEND, 0, 18'sd65536, 18'sd12345, 0);
    send_beat(setbl_pkg::OP_APPEND, 0, 0, 1, 0);
    send_beat(setbl_pkg::OP_SORT, 0, 0, 0, 0);
    for (int i = 0; i <= 5; i++) send_beat(setbl_pkg::OP_READ, SLOT_W'(i), 0, 0, 0);
    send_beat(setbl_pkg::OP_READ, 16'hFFFF, 0, 0, 0);
    send_beat(OP_UNUSED, 16'hFFFF, POS_MAX, POS_MAX, 16'hFFFF);
    send_beat(setbl_pkg::OP_SET_POS, 1, POS_MAX, 0, 0);
    send_beat(setbl_pkg::OP_SET_VEL, 1, 0, NEG_MIN, 0);
    send_beat(setbl_pkg::OP_SET_VEL, 16'hFFFF, 0, 18'sd100, 0);
    send_beat(setbl_pkg::OP_RESIZE, 0, 0, 0, 2);
    send_beat(setbl_pkg::OP_READ, 2, 0, 0, 0);
    send_beat(setbl_pkg::OP_RESIZE, 0, 0, 0, 4);
    send_beat(setbl_pkg::OP_READ, 3, 0, 0, 0);
    send_beat(setbl_pkg::OP_RESIZE, 0, 0, 0, 16'hFFFF);
    send_beat(setbl_pkg::OP_APPEND, 0, 18'sd7, 18'sd7, 0);
    send_beat(setbl_pkg::OP_READ, SLOT_W'(TABLE_DEPTH - 1), 0, 0, 0);
    send_beat(setbl_pkg::OP_SORT, 0, 0, 0, 0);
    send_beat(setbl_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_beat(setbl_pkg::OP_READ, 0, 0, 0, 0);
    wait_drained();

    run_mix(450);

    hold_cycles = 400;
    repeat (40) random_beat();
    wait_drained();

    run_mix(950);

    idle_on = 1'b0;
    wait_drained();
    run_mix(1250);

    wait_drained();
    repeat (20) @(posedge clk);
    if (table_sb.errors == 0) begin
      $display("tb_sortable_event_table_unit: done, clean");
    end else begin
      $display("tb_sortable_event_table_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/setbl_pkg.sv
rtl/setbl_store.sv
rtl/setbl_seq.sv
rtl/sortable_event_table_unit.sv
rtl/setbl_checker.sv
tb/tb_sortable_event_table_unit.sv
